/* sv/mpb_pkg.sv */
package mpb_pkg;

  // Table sizes.
  localparam int MAX_MODES    = 8;
  localparam int MAX_RECORDS  = 256;
  localparam int MAX_SWITCHES = 64;
  localparam int MAX_PATH     = 256;

  localparam int MODE_W     = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int REC_IDX_W  = $clog2(MAX_RECORDS);
  localparam int REC_CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int REC_AW     = MODE_W + REC_IDX_W;
  localparam int SW_IDX_W   = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;
  localparam int SW_CNT_W   = $clog2(MAX_SWITCHES + 1);
  localparam int SW_AW      = MODE_W + SW_IDX_W;
  localparam int PATH_IDX_W = $clog2(MAX_PATH);
  localparam int PATH_CNT_W = $clog2(MAX_PATH + 1);
  localparam int MC_W       = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // Function codes of the input channel.
  localparam logic [2:0] FN_CLEAR    = 3'd0;
  localparam logic [2:0] FN_LOAD_REC = 3'd1;
  localparam logic [2:0] FN_LOAD_SW  = 3'd2;
  localparam logic [2:0] FN_QUERY    = 3'd3;
  localparam logic [2:0] FN_READ     = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD_REC,
    OP_LOAD_SW,
    OP_QUERY,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_PATH  = 3'd2,
    ST_RANGE    = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ_WAIT,
    BK_SW_RD,
    BK_SW_CMP,
    BK_REC_RD,
    BK_REC_CMP
  } bk_state_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  mode;
    logic [63:0] vertex;
    logic [63:0] link;
    logic [7:0]  read_index;
  } cmd_t;

  typedef struct packed {
    logic [63:0] vtx;
    logic [63:0] par;
  } rec_ent_t;

  typedef struct packed {
    logic [63:0] from_vtx;
    logic [63:0] to_vtx;
  } sw_ent_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] vertex;
    logic        seg_first;
  } path_ent_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  path_length;
    logic [2:0]  mode;
    logic [63:0] vertex;
    logic        mode_last;
    logic        path_last;
  } result_t;

  function automatic op_t classify(input logic [2:0] func);
    op_t op;
    case (func)
      FN_CLEAR:    op = OP_CLEAR;
      FN_LOAD_REC: op = OP_LOAD_REC;
      FN_LOAD_SW:  op = OP_LOAD_SW;
      FN_QUERY:    op = OP_QUERY;
      FN_READ:     op = OP_READ;
      default:     op = OP_NOP;
    endcase
    return op;
  endfunction

  function automatic result_t plain_result(input status_t st,
                                           input logic [PATH_CNT_W-1:0] total);
    result_t r;
    r             = '0;
    r.status      = st;
    r.path_length = 9'(total);
    return r;
  endfunction

endpackage

/* sv/mpb_front.sv */
module mpb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [2:0]          in_func,
  input  logic [2:0]          in_mode,
  input  logic signed [63:0]  in_vertex_id,
  input  logic signed [63:0]  in_link_id,
  input  logic [7:0]          in_read_index,
  output mpb_pkg::cmd_t       cmd,
  output logic                cmd_valid,
  input  logic                cmd_pop
);

  mpb_pkg::cmd_t                q_r [mpb_pkg::QUEUE_DEPTH];
  logic [mpb_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [mpb_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [mpb_pkg::QUEUE_AW:0]   cnt_r;
  logic                         push_ok;
  logic                         pop_ok;
  mpb_pkg::cmd_t                new_cmd;

  assign in_full   = (cnt_r == (mpb_pkg::QUEUE_AW + 1)'(mpb_pkg::QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign push_ok   = in_push & ~in_full;
  assign pop_ok    = cmd_pop & cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // Decode the function code once so the back end sees a clean operation.
  always_comb begin
    new_cmd            = '0;
    new_cmd.op         = mpb_pkg::classify(in_func);
    new_cmd.mode       = in_mode;
    new_cmd.vertex     = in_vertex_id;
    new_cmd.link       = in_link_id;
    new_cmd.read_index = in_read_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == mpb_pkg::QUEUE_AW'(mpb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == mpb_pkg::QUEUE_AW'(mpb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

/* sv/mpb_back.sv */
module mpb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpb_pkg::cmd_t                 cmd,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  logic [mpb_pkg::MC_W-1:0]      mode_count,
  output mpb_pkg::result_t              res,
  output logic                          res_valid,
  input  logic                          res_pop
);

  localparam int RD = mpb_pkg::REC_CNT_W;
  localparam int SD = mpb_pkg::SW_CNT_W;
  localparam int PD = mpb_pkg::PATH_CNT_W;
  localparam int MW = mpb_pkg::MODE_W;

  // Memories.
  mpb_pkg::rec_ent_t  rec_mem  [2**mpb_pkg::REC_AW];
  mpb_pkg::sw_ent_t   sw_mem   [2**mpb_pkg::SW_AW];
  mpb_pkg::path_ent_t path_mem [2**mpb_pkg::PATH_IDX_W];
  mpb_pkg::rec_ent_t  rec_rd_r;
  mpb_pkg::sw_ent_t   sw_rd_r;
  mpb_pkg::path_ent_t path_rd_r;

  logic                              rec_we, rec_re, sw_we, sw_re, path_we, path_re;
  logic [mpb_pkg::REC_AW-1:0]        rec_waddr, rec_raddr;
  logic [mpb_pkg::SW_AW-1:0]         sw_waddr, sw_raddr;
  logic [mpb_pkg::PATH_IDX_W-1:0]    path_waddr, path_raddr;
  mpb_pkg::path_ent_t                path_wdata;

  // Control state.
  mpb_pkg::bk_state_t state_r, state_nxt;
  logic [RD-1:0]      rec_cnt_r [mpb_pkg::MAX_MODES];
  logic [RD-1:0]      rec_cnt_nxt [mpb_pkg::MAX_MODES];
  logic [SD-1:0]      sw_cnt_r [mpb_pkg::MAX_MODES];
  logic [SD-1:0]      sw_cnt_nxt [mpb_pkg::MAX_MODES];
  logic [PD-1:0]      total_r, total_nxt;
  logic               res_valid_r, res_valid_nxt;
  mpb_pkg::result_t   res_r, res_nxt;

  // Walk datapath.
  logic [MW-1:0]      k_r, k_nxt;
  logic [PD-1:0]      n_r, n_nxt;
  logic [RD-1:0]      len_r, len_nxt;
  logic [RD-1:0]      ridx_r, ridx_nxt;
  logic [SD-1:0]      sidx_r, sidx_nxt;
  logic [63:0]        key_r, key_nxt;
  logic [63:0]        root_r, root_nxt;
  logic               plast_r, plast_nxt;

  logic               take;
  logic [MW-1:0]      cnt_idx;
  logic [RD-1:0]      rec_cnt_sel;
  logic [SD-1:0]      sw_cnt_sel;
  logic               mode_ok;
  logic [PD-1:0]      read_ext;
  logic               read_oob;
  logic [MW-1:0]      k_start;
  logic               rec_hit, sw_hit, seg_end, walk_cycle, walk_full;

  assign take      = (state_r == mpb_pkg::BK_IDLE) && cmd_valid && (!res_valid_r || res_pop);
  assign cmd_pop   = take;
  assign res       = res_r;
  assign res_valid = res_valid_r;

  assign cnt_idx     = (state_r == mpb_pkg::BK_IDLE) ? MW'(cmd.mode) : k_r;
  assign rec_cnt_sel = rec_cnt_r[cnt_idx];
  assign sw_cnt_sel  = sw_cnt_r[cnt_idx];
  assign mode_ok     = (int'(cmd.mode) < mpb_pkg::MAX_MODES);
  assign read_ext    = PD'(cmd.read_index);
  assign read_oob    = (read_ext >= total_r);

  // A mode count of zero behaves as one; larger than the table set saturates.
  always_comb begin
    if (mode_count == '0) begin
      k_start = '0;
    end else if (int'(mode_count) > mpb_pkg::MAX_MODES) begin
      k_start = MW'(mpb_pkg::MAX_MODES - 1);
    end else begin
      k_start = MW'(mode_count - 1'b1);
    end
  end

  assign rec_hit    = (rec_rd_r.vtx == key_r);
  assign sw_hit     = (sw_rd_r.to_vtx == root_r);
  assign seg_end    = (rec_rd_r.par == rec_rd_r.vtx);
  assign walk_cycle = (len_r >= rec_cnt_sel);
  assign walk_full  = (n_r >= PD'(mpb_pkg::MAX_PATH));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpb_pkg::BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            mpb_pkg::OP_READ:  state_nxt = read_oob ? mpb_pkg::BK_IDLE : mpb_pkg::BK_READ_WAIT;
            mpb_pkg::OP_QUERY: state_nxt = mpb_pkg::BK_REC_RD;
            default:           state_nxt = mpb_pkg::BK_IDLE;
          endcase
        end
      end
      mpb_pkg::BK_READ_WAIT: state_nxt = mpb_pkg::BK_IDLE;
      mpb_pkg::BK_SW_RD: begin
        state_nxt = (sidx_r == sw_cnt_sel) ? mpb_pkg::BK_IDLE : mpb_pkg::BK_SW_CMP;
      end
      mpb_pkg::BK_SW_CMP: begin
        state_nxt = sw_hit ? mpb_pkg::BK_REC_RD : mpb_pkg::BK_SW_RD;
      end
      mpb_pkg::BK_REC_RD: begin
        state_nxt = (ridx_r == rec_cnt_sel) ? mpb_pkg::BK_IDLE : mpb_pkg::BK_REC_CMP;
      end
      mpb_pkg::BK_REC_CMP: begin
        if (!rec_hit) begin
          state_nxt = mpb_pkg::BK_REC_RD;
        end else if (walk_cycle || walk_full) begin
          state_nxt = mpb_pkg::BK_IDLE;
        end else if (seg_end) begin
          state_nxt = (k_r == '0) ? mpb_pkg::BK_IDLE : mpb_pkg::BK_SW_RD;
        end else begin
          state_nxt = mpb_pkg::BK_REC_RD;
        end
      end
      default: state_nxt = mpb_pkg::BK_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    rec_cnt_nxt   = rec_cnt_r;
    sw_cnt_nxt    = sw_cnt_r;
    total_nxt     = total_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r & ~res_pop;
    k_nxt         = k_r;
    n_nxt         = n_r;
    len_nxt       = len_r;
    ridx_nxt      = ridx_r;
    sidx_nxt      = sidx_r;
    key_nxt       = key_r;
    root_nxt      = root_r;
    plast_nxt     = plast_r;
    rec_we        = 1'b0;
    rec_re        = 1'b0;
    sw_we         = 1'b0;
    sw_re         = 1'b0;
    path_we       = 1'b0;
    path_re       = 1'b0;
    rec_waddr     = {cnt_idx, rec_cnt_sel[mpb_pkg::REC_IDX_W-1:0]};
    sw_waddr      = {cnt_idx, sw_cnt_sel[mpb_pkg::SW_IDX_W-1:0]};
    rec_raddr     = {k_r, ridx_r[mpb_pkg::REC_IDX_W-1:0]};
    sw_raddr      = {k_r, sidx_r[mpb_pkg::SW_IDX_W-1:0]};
    path_waddr    = n_r[mpb_pkg::PATH_IDX_W-1:0];
    path_raddr    = mpb_pkg::PATH_IDX_W'(total_r - 1'b1 - read_ext);
    path_wdata.mode      = 3'(k_r);
    path_wdata.vertex    = rec_rd_r.vtx;
    path_wdata.seg_first = (len_r == '0);

    case (state_r)
      mpb_pkg::BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            mpb_pkg::OP_CLEAR: begin
              for (int m = 0; m < mpb_pkg::MAX_MODES; m++) begin
                rec_cnt_nxt[m] = '0;
                sw_cnt_nxt[m]  = '0;
              end
              total_nxt     = '0;
              res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_OK, '0);
              res_valid_nxt = 1'b1;
            end
            mpb_pkg::OP_LOAD_REC: begin
              if (!mode_ok || rec_cnt_sel >= RD'(mpb_pkg::MAX_RECORDS)) begin
                res_nxt = mpb_pkg::plain_result(mpb_pkg::ST_FULL, total_r);
              end else begin
                rec_we               = 1'b1;
                rec_cnt_nxt[cnt_idx] = rec_cnt_sel + 1'b1;
                res_nxt = mpb_pkg::plain_result(mpb_pkg::ST_OK, total_r);
              end
              res_valid_nxt = 1'b1;
            end
            mpb_pkg::OP_LOAD_SW: begin
              if (!mode_ok || sw_cnt_sel >= SD'(mpb_pkg::MAX_SWITCHES)) begin
                res_nxt = mpb_pkg::plain_result(mpb_pkg::ST_FULL, total_r);
              end else begin
                sw_we               = 1'b1;
                sw_cnt_nxt[cnt_idx] = sw_cnt_sel + 1'b1;
                res_nxt = mpb_pkg::plain_result(mpb_pkg::ST_OK, total_r);
              end
              res_valid_nxt = 1'b1;
            end
            mpb_pkg::OP_QUERY: begin
              total_nxt = '0;
              k_nxt     = k_start;
              key_nxt   = cmd.vertex;
              ridx_nxt  = '0;
              len_nxt   = '0;
              n_nxt     = '0;
            end
            mpb_pkg::OP_READ: begin
              if (read_oob) begin
                res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_RANGE, total_r);
                res_valid_nxt = 1'b1;
              end else begin
                path_re   = 1'b1;
                plast_nxt = ((read_ext + 1'b1) == total_r);
              end
            end
            default: begin
              res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_OK, total_r);
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      mpb_pkg::BK_READ_WAIT: begin
        res_nxt           = mpb_pkg::plain_result(mpb_pkg::ST_OK, total_r);
        res_nxt.mode      = path_rd_r.mode;
        res_nxt.vertex    = path_rd_r.vertex;
        res_nxt.mode_last = path_rd_r.seg_first;
        res_nxt.path_last = plast_r;
        res_valid_nxt     = 1'b1;
      end
      mpb_pkg::BK_SW_RD: begin
        if (sidx_r == sw_cnt_sel) begin
          res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_NO_PATH, '0);
          res_valid_nxt = 1'b1;
        end else begin
          sw_re = 1'b1;
        end
      end
      mpb_pkg::BK_SW_CMP: begin
        if (sw_hit) begin
          key_nxt  = sw_rd_r.from_vtx;
          ridx_nxt = '0;
        end else begin
          sidx_nxt = sidx_r + 1'b1;
        end
      end
      mpb_pkg::BK_REC_RD: begin
        if (ridx_r == rec_cnt_sel) begin
          res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_NO_PATH, '0);
          res_valid_nxt = 1'b1;
        end else begin
          rec_re = 1'b1;
        end
      end
      mpb_pkg::BK_REC_CMP: begin
        if (!rec_hit) begin
          ridx_nxt = ridx_r + 1'b1;
        end else if (walk_cycle) begin
          res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_NO_PATH, '0);
          res_valid_nxt = 1'b1;
        end else if (walk_full) begin
          res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_TOO_LONG, '0);
          res_valid_nxt = 1'b1;
        end else begin
          path_we = 1'b1;
          n_nxt   = n_r + 1'b1;
          len_nxt = len_r + 1'b1;
          if (seg_end) begin
            if (k_r == '0) begin
              total_nxt     = n_r + 1'b1;
              res_nxt       = mpb_pkg::plain_result(mpb_pkg::ST_OK, n_r + 1'b1);
              res_valid_nxt = 1'b1;
            end else begin
              k_nxt    = k_r - 1'b1;
              root_nxt = rec_rd_r.vtx;
              sidx_nxt = '0;
              len_nxt  = '0;
            end
          end else begin
            key_nxt  = rec_rd_r.par;
            ridx_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpb_pkg::BK_IDLE;
      total_r     <= '0;
      res_valid_r <= 1'b0;
      for (int m = 0; m < mpb_pkg::MAX_MODES; m++) begin
        rec_cnt_r[m] <= '0;
        sw_cnt_r[m]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      res_valid_r <= res_valid_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    len_r   <= len_nxt;
    ridx_r  <= ridx_nxt;
    sidx_r  <= sidx_nxt;
    key_r   <= key_nxt;
    root_r  <= root_nxt;
    plast_r <= plast_nxt;
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= {cmd.vertex, cmd.link};
    end
    if (rec_re) begin
      rec_rd_r <= rec_mem[rec_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sw_we) begin
      sw_mem[sw_waddr] <= {cmd.vertex, cmd.link};
    end
    if (sw_re) begin
      sw_rd_r <= sw_mem[sw_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    if (path_re) begin
      path_rd_r <= path_mem[path_raddr];
    end
  end

endmodule

/* sv/multimode_path_backtrace_core.sv */
// Multimode path backtrace core.
// Requests enter through a queue-style port: drive the fields with in_push high
// and the request is taken at a clock edge where in_full is low. Every request
// yields exactly one result, presented while out_empty is low and removed by
// out_pop. A two-entry request queue sits in front of the execution engine and
// a result register sits behind it, so new requests are taken while a result
// waits; when the receiver stalls, the engine stops after one result and the
// request queue fills and raises in_full.
// Clear, load and unused requests are answered in the result register when
// taken; a path read adds a registered path memory read before its result.
// A query walks the tables in the engine: each table entry it examines costs
// one registered memory read and one compare, and the walk is bounded by the
// loaded table sizes. The mode_count register sits at byte address 0 of the
// APB port and is to be written only while the block is idle; the block itself
// does not enforce this. Synchronous reset empties the queue, the result
// register and all table counts, forgets any stored path and sets mode_count
// to 1. Table contents are not cleared; only counted entries are read.
module multimode_path_backtrace_core (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel.
  input  logic                in_push,
  output logic                in_full,
  input  logic [2:0]          in_func,
  input  logic [2:0]          in_mode,
  input  logic signed [63:0]  in_vertex_id,
  input  logic signed [63:0]  in_link_id,
  input  logic [7:0]          in_read_index,
  // Result channel.
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_status,
  output logic [8:0]          out_path_length,
  output logic [2:0]          out_out_mode,
  output logic signed [63:0]  out_out_vertex,
  output logic                out_mode_last,
  output logic                out_path_last,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  mpb_pkg::cmd_t                  cmd;
  logic                           cmd_valid;
  logic                           cmd_pop;
  mpb_pkg::result_t               res;
  logic                           res_valid;
  logic [mpb_pkg::MC_W-1:0]       mode_count_r;
  logic                           reg_sel;

  // The single register decodes on the word address bit; byte bits are ignored.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {{(32 - mpb_pkg::MC_W){1'b0}}, mode_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_count_r <= mpb_pkg::MC_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      mode_count_r <= pwdata[mpb_pkg::MC_W-1:0];
    end
  end

  // Front end: takes requests and classifies them into the queue.
  mpb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_mode      (in_mode),
    .in_vertex_id (in_vertex_id),
    .in_link_id   (in_link_id),
    .in_read_index(in_read_index),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop)
  );

  // Back end: owns the tables, the path buffer and the backtrace sequencer.
  mpb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .mode_count(mode_count_r),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (out_pop)
  );

  assign out_empty       = ~res_valid;
  assign out_status      = res.status;
  assign out_path_length = res.path_length;
  assign out_out_mode    = res.mode;
  assign out_out_vertex  = res.vertex;
  assign out_mode_last   = res.mode_last;
  assign out_path_last   = res.path_last;

  // A full request queue always has a request for the engine.
  a_full_has_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> cmd_valid) else $error("request queue full but empty to engine");

  // The end of the whole path also ends its mode segment.
  a_last_nesting : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_path_last) |-> out_mode_last)
    else $error("path end without segment end");

  // Only a successful read carries entry data.
  a_fail_no_data : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != mpb_pkg::ST_OK) |->
      (out_out_vertex == '0 && !out_path_last && !out_mode_last))
    else $error("failed request carries entry data");

  // A failed query never leaves a stored path behind.
  a_fail_clears_path : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == mpb_pkg::ST_NO_PATH ||
                    out_status == mpb_pkg::ST_TOO_LONG)) |-> (out_path_length == '0))
    else $error("failed query left a path length");

endmodule
